[rtl/chsg_pkg.sv]
// Shared types and constants for the disk CHS geometry block.
`default_nettype none
package chsg_pkg;

  localparam int SECTOR_BITS = 9;
  localparam int BYTES_W     = 40;
  localparam int TOTAL_W     = 24;
  localparam int DIVISOR_W   = 6;
  localparam int CYL_W       = 15;
  localparam int HEAD_W      = 5;

  localparam logic [BYTES_W-SECTOR_BITS-1:0] LARGE_SECTORS = 31'd16514064;
  localparam logic [CYL_W-1:0]     LARGE_CYLS  = 15'd16383;
  localparam logic [HEAD_W-1:0]    LARGE_HEADS = 5'd16;
  localparam logic [DIVISOR_W-1:0] LARGE_SPT   = 6'd63;
  localparam logic [TOTAL_W-1:0]   CYL_LIMIT   = 24'd16384;

  typedef struct packed {
    logic                 start;
    logic [TOTAL_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TOTAL_W-1:0]   quot;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

[rtl/chsg_div.sv]
// Bit-serial restoring divider: 24-bit dividend by 6-bit divisor, one bit per cycle.
`default_nettype none
module chsg_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire chsg_pkg::div_req_t req,
  output chsg_pkg::div_rsp_t     rsp
);

  localparam int CNT_W = $clog2(chsg_pkg::TOTAL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(chsg_pkg::TOTAL_W - 1);

  logic                           busy;
  logic                           done;
  logic [CNT_W-1:0]               cnt;
  logic [chsg_pkg::TOTAL_W-1:0]   dvd;
  logic [chsg_pkg::DIVISOR_W-1:0] dvs;
  logic [chsg_pkg::DIVISOR_W-1:0] rem;
  logic [chsg_pkg::DIVISOR_W-1:0] rem_next;
  logic [chsg_pkg::DIVISOR_W:0]   trial;
  logic                           qbit;

  always_comb begin
    trial    = {rem, dvd[chsg_pkg::TOTAL_W-1]};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? chsg_pkg::DIVISOR_W'(trial - {1'b0, dvs})
                    : trial[chsg_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[chsg_pkg::TOTAL_W-2:0], qbit};
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

[rtl/disk_chs_geometry_from_size_core.sv]
// Top level: CHS geometry from image size, sequencer around a shared serial divider.
// Timing: an image at or above the large-disk size goes straight to the result with no
//   division; otherwise each trial division runs launch, one divider step per dividend bit,
//   then result, for up to (MAX_HEADS-1)+(MAX_SECTORS-1) trials.
// Throughput: one image at a time; in_stall is high from transfer until the result leaves.
// Reset: synchronous, active high; returns to idle with no result pending.
`default_nettype none
module disk_chs_geometry_from_size_core #(
  parameter int MAX_HEADS   = 16,
  parameter int MAX_SECTORS = 63
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [39:0] image_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [14:0]      cylinders,
  output logic [4:0]       heads,
  output logic [5:0]       sectors_per_track,
  output logic             used_fallback,
  output logic             partial_sector
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_SPT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [chsg_pkg::DIVISOR_W-1:0] HEAD_TOP = chsg_pkg::DIVISOR_W'(MAX_HEADS);
  localparam logic [chsg_pkg::DIVISOR_W-1:0] SPT_TOP  = chsg_pkg::DIVISOR_W'(MAX_SECTORS);
  localparam logic [chsg_pkg::DIVISOR_W-1:0] CAND_MIN = chsg_pkg::DIVISOR_W'(2);

  logic [1:0]                     state;
  logic                           launch;
  logic [chsg_pkg::TOTAL_W-1:0]   total;
  logic [chsg_pkg::TOTAL_W-1:0]   per_head;
  logic [chsg_pkg::DIVISOR_W-1:0] cand;
  logic [chsg_pkg::TOTAL_W-1:0]   div_dividend;
  logic [chsg_pkg::TOTAL_W-1:0]   cyl_full;
  logic                           fit_fallback;
  chsg_pkg::div_req_t             div_req;
  chsg_pkg::div_rsp_t             div_rsp;

  assign div_req.start    = launch;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = cand;

  chsg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (div_rsp.rem == '0) begin
      cyl_full = div_rsp.quot;
    end else begin
      cyl_full = per_head;
    end
    fit_fallback = (cyl_full > chsg_pkg::CYL_LIMIT);
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            partial_sector <= |image_bytes[chsg_pkg::SECTOR_BITS-1:0];
            if (image_bytes[39:chsg_pkg::SECTOR_BITS] >= chsg_pkg::LARGE_SECTORS) begin
              used_fallback     <= 1'b1;
              cylinders         <= chsg_pkg::LARGE_CYLS;
              heads             <= chsg_pkg::LARGE_HEADS;
              sectors_per_track <= chsg_pkg::LARGE_SPT;
              state             <= S_DONE;
            end else begin
              total <= image_bytes[chsg_pkg::SECTOR_BITS +: chsg_pkg::TOTAL_W];
              div_dividend <= image_bytes[chsg_pkg::SECTOR_BITS +: chsg_pkg::TOTAL_W];
              cand   <= HEAD_TOP;
              launch <= 1'b1;
              state  <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0 || cand == CAND_MIN) begin
              if (div_rsp.rem == '0) begin
                heads        <= chsg_pkg::HEAD_W'(cand);
                per_head     <= div_rsp.quot;
                div_dividend <= div_rsp.quot;
              end else begin
                heads        <= chsg_pkg::HEAD_W'(1);
                per_head     <= total;
                div_dividend <= total;
              end
              cand  <= SPT_TOP;
              state <= S_SPT;
            end else begin
              cand <= cand - 1'b1;
            end
            launch <= 1'b1;
          end
        end
        S_SPT: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0 || cand == CAND_MIN) begin
              if (fit_fallback) begin
                used_fallback     <= 1'b1;
                cylinders         <= chsg_pkg::LARGE_CYLS;
                heads             <= chsg_pkg::LARGE_HEADS;
                sectors_per_track <= chsg_pkg::LARGE_SPT;
              end else begin
                used_fallback     <= 1'b0;
                cylinders         <= chsg_pkg::CYL_W'(cyl_full);
                sectors_per_track <= (div_rsp.rem == '0) ? cand
                                                          : chsg_pkg::DIVISOR_W'(1);
              end
              state <= S_DONE;
            end else begin
              cand   <= cand - 1'b1;
              launch <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input transfer did not make the block busy");

  a_fallback_geom: assert property (@(posedge clk) disable iff (rst)
    out_valid && used_fallback |-> cylinders == chsg_pkg::LARGE_CYLS &&
      heads == chsg_pkg::LARGE_HEADS && sectors_per_track == chsg_pkg::LARGE_SPT)
    else $error("fallback result without large-disk geometry");

  a_fit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !used_fallback |-> cylinders <= 15'd16384 && heads != '0 &&
      sectors_per_track != '0)
    else $error("fitted geometry out of range");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_HEAD || state == S_SPT)
    else $error("divider result outside a trial phase");
`endif

endmodule
`default_nettype wire
